// File: hw/rtl/ppm_rgb_stream_splitter_unit_macros.svh
// assertion macros for the ppm rgb stream splitter
`ifndef PPM_RGB_STREAM_SPLITTER_UNIT_MACROS_SVH
`define PPM_RGB_STREAM_SPLITTER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PPMRGB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PPMRGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ppmrgb_pkg.sv
// types and constants for the ppm rgb stream splitter
`timescale 1ns / 1ps

package ppmrgb_pkg;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   localparam int RSP_DATA_BITS = 56;

   typedef struct packed {
      logic [1:0]  channel;
      logic [7:0]  sample;
      logic [15:0] pixel_column;
      logic [15:0] pixel_row;
      logic [15:0] max_value;
      logic        last_of_image;
   } ppmrgb_result_type;

endpackage

// File: hw/rtl/ppm_rgb_stream_splitter_unit.sv
// top level of the ppm rgb stream splitter: header parse and rgb sample tagging
`timescale 1ns / 1ps
`include "ppm_rgb_stream_splitter_unit_macros.svh"
//
// usage
//   req channel: one byte of a binary ppm (p6) file per request on req_tdata
//   header: whitespace separated tokens; tokens with a non-digit are dropped,
//   the first three numeric tokens give width, height and maxval, and the
//   whitespace byte ending maxval ends the header (header bytes give no output)
//   rsp channel: one result per data byte inside the image, carrying the
//   sample, its pixel column and row, maxval, the color on rsp_tuser and
//   rsp_tlast on the blue sample of the final pixel
//   bytes past the image, or any data when width or height is zero, give nothing
//   an accepted data byte is registered, into the skid register if rsp is held
//   throughput: one byte per cycle while req_tready is high, set by the single state update per byte
//   stall: a result held on rsp waits while one more result goes to a skid
//   register; req_tready drops only while that skid register is full
//   reset: synchronous, active high; returns to header parsing with all
//   counts and header values cleared and both output registers empty
//
module ppm_rgb_stream_splitter_unit
   import ppmrgb_pkg::*;
#(
   parameter int DIM_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // byte_in[7:0]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // sample[7:0], pixel_column[23:8], pixel_row[39:24], max_value[55:40]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [1:0]               rsp_tuser,   // channel[1:0]
   output logic                     rsp_tlast    // last_of_image
);

   // parser phase codes
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_DATA   = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   // accumulator holds ten times the largest value plus a digit
   localparam int ACC_BITS = DIM_BITS + 4;

   // parser and image state
   logic [1:0]          phase_ff, phase_in;
   logic [1:0]          field_ff, field_in;
   logic [DIM_BITS-1:0] number_ff, number_in;
   logic                has_chars_ff, has_chars_in;
   logic                bad_ff, bad_in;
   logic [DIM_BITS-1:0] width_ff, width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   logic [DIM_BITS-1:0] maxval_ff, maxval_in;
   logic [1:0]          chan_ff, chan_in;
   logic [DIM_BITS-1:0] col_ff, col_in;
   logic [DIM_BITS-1:0] row_ff, row_in;

   // output register and skid register
   logic                rsp_valid_ff, rsp_valid_in;
   ppmrgb_result_type   rsp_ff, rsp_in;
   logic                skid_valid_ff, skid_valid_in;
   ppmrgb_result_type   skid_ff, skid_in;

   logic                req_take;
   logic                rsp_take;
   logic                produce;
   logic                is_space;
   logic                is_digit;
   logic [ACC_BITS-1:0] acc;
   logic [DIM_BITS:0]   col_inc;
   logic [DIM_BITS:0]   row_inc;
   logic [31:0]         col_wide;
   logic [31:0]         row_wide;
   logic [31:0]         maxval_wide;
   ppmrgb_result_type   new_result;

   assign req_tready = !skid_valid_ff;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_take   = rsp_valid_ff && rsp_tready;
   assign produce    = req_take && (phase_ff == PH_DATA);

   assign is_space = req_tdata inside {[8'd9:8'd13], 8'd32};
   assign is_digit = req_tdata inside {[8'h30:8'h39]};

   // decimal step: number * 8 + number * 2 + digit
   assign acc = ({4'b0000, number_ff} << 3) + ({4'b0000, number_ff} << 1)
              + ACC_BITS'(req_tdata[3:0]);

   assign col_inc = {1'b0, col_ff} + 1'b1;
   assign row_inc = {1'b0, row_ff} + 1'b1;

   // output fields carry the low 16 bits of the dimension counters
   assign col_wide    = 32'(col_ff);
   assign row_wide    = 32'(row_ff);
   assign maxval_wide = 32'(maxval_ff);

   always_comb begin
      new_result.channel       = chan_ff;
      new_result.sample        = req_tdata;
      new_result.pixel_column  = col_wide[15:0];
      new_result.pixel_row     = row_wide[15:0];
      new_result.max_value     = maxval_wide[15:0];
      new_result.last_of_image = (chan_ff == CH_BLUE) && (col_inc == {1'b0, width_ff})
                              && (row_inc == {1'b0, height_ff});
   end

   // header parse and pixel counting, one byte per accepted request
   always_comb begin
      phase_in     = phase_ff;
      field_in     = field_ff;
      number_in    = number_ff;
      has_chars_in = has_chars_ff;
      bad_in       = bad_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      maxval_in    = maxval_ff;
      chan_in      = chan_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      if (req_take) begin
         case (phase_ff)
            PH_HEADER: begin
               if (is_space) begin
                  // end of token; empty or non-numeric tokens are dropped
                  if (has_chars_ff && !bad_ff) begin
                     case (field_ff)
                        2'd0:    width_in  = number_ff;
                        2'd1:    height_in = number_ff;
                        default: maxval_in = number_ff;
                     endcase
                     field_in = field_ff + 2'd1;
                     if (field_ff == 2'd2) begin
                        phase_in = ((width_ff == '0) || (height_ff == '0)) ? PH_DONE
                                                                           : PH_DATA;
                     end
                  end
                  number_in    = '0;
                  has_chars_in = 1'b0;
                  bad_in       = 1'b0;
               end else begin
                  has_chars_in = 1'b1;
                  if (is_digit) begin
                     // saturate at the dimension limit
                     number_in = (|acc[ACC_BITS-1:DIM_BITS]) ? '1 : acc[DIM_BITS-1:0];
                  end else begin
                     bad_in = 1'b1;
                  end
               end
            end
            PH_DATA: begin
               if (chan_ff == CH_BLUE) begin
                  chan_in = CH_RED;
                  if (col_inc >= {1'b0, width_ff}) begin
                     col_in = '0;
                     row_in = row_inc[DIM_BITS-1:0];
                     if (row_inc >= {1'b0, height_ff}) begin
                        phase_in = PH_DONE;
                     end
                  end else begin
                     col_in = col_inc[DIM_BITS-1:0];
                  end
               end else begin
                  chan_in = chan_ff + 2'd1;
               end
            end
            default: begin
               // done: trailing bytes are swallowed
            end
         endcase
      end
   end

   // output register with skid stage behind it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = produce;
            rsp_in       = new_result;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_in       = new_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         field_ff      <= 2'd0;
         number_ff     <= '0;
         has_chars_ff  <= 1'b0;
         bad_ff        <= 1'b0;
         width_ff      <= '0;
         height_ff     <= '0;
         maxval_ff     <= '0;
         chan_ff       <= CH_RED;
         col_ff        <= '0;
         row_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         field_ff      <= field_in;
         number_ff     <= number_in;
         has_chars_ff  <= has_chars_in;
         bad_ff        <= bad_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         maxval_ff     <= maxval_in;
         chan_ff       <= chan_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.max_value, rsp_ff.pixel_row, rsp_ff.pixel_column,
                        rsp_ff.sample};
   assign rsp_tuser  = rsp_ff.channel;
   assign rsp_tlast  = rsp_ff.last_of_image;

   // checks
   `PPMRGB_ASSERT_NOW(a_skid_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff,
      "skid register full while output register empty")
   `PPMRGB_ASSERT_NOW(a_no_rsp_in_header, clock, reset, phase_ff == PH_HEADER,
      !rsp_valid_ff && !skid_valid_ff, "result produced during header")
   `PPMRGB_ASSERT_NOW(a_last_is_blue, clock, reset, rsp_valid_ff && rsp_ff.last_of_image,
      rsp_ff.channel == CH_BLUE, "last flag on a non-blue sample")
   `PPMRGB_ASSERT_NOW(a_col_in_range, clock, reset, phase_ff == PH_DATA,
      col_ff < width_ff && row_ff < height_ff, "pixel position outside the image")
   `PPMRGB_ASSERT_NEXT(a_red_then_green, clock, reset, produce && chan_ff == CH_RED,
      chan_ff == CH_GREEN, "channel did not advance after red")

endmodule
